// ===== design/assert_macros.svh =====
// Assertion macros shared by the noise generator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gng_pkg.sv =====
// Shared constants and types of the Gaussian noise generator.
// No dependencies; used by the square-root cell and chain, the top level and the testbench.
package gng_pkg;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned SAMPLE_W    = 20;
    localparam int unsigned SQRT_STEPS  = 32;

    localparam logic [63:0] PCG_MULT    = 64'd6364136223846793005;
    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // One stage of the bit-pair square root: remainder, partial root, trial bit.
    typedef struct packed {
        logic        valid;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
    } sqrt_stage_t;

endpackage

// ===== design/gng_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per transfer.
// Depends on gng_pkg for the stage type.
module gng_sqrt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  gng_pkg::sqrt_stage_t stage_in,
    output gng_pkg::sqrt_stage_t stage_out
);
    import gng_pkg::*;

    logic [63:0] probe;
    logic        take;

    assign probe = stage_in.root + stage_in.trial;
    assign take  = stage_in.rem >= probe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_out.valid <= 1'b0;
        end else begin
            stage_out.valid <= stage_in.valid;
        end
        // advance the trial bit by one bit pair
        stage_out.trial <= stage_in.trial >> 2;
        if (take) begin
            stage_out.rem  <= stage_in.rem - probe;
            stage_out.root <= (stage_in.root >> 1) + stage_in.trial;
        end else begin
            stage_out.rem  <= stage_in.rem;
            stage_out.root <= stage_in.root >> 1;
        end
    end

endmodule

// ===== design/gng_sqrt_chain.sv =====
// Row of square-root cells; a 64-bit radicand enters, its root leaves the
// last registered cell of the row. Depends on gng_pkg and gng_sqrt_cell.
`include "assert_macros.svh"

module gng_sqrt_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  gng_pkg::sqrt_stage_t chain_in,
    output gng_pkg::sqrt_stage_t chain_out
);
    import gng_pkg::*;

    sqrt_stage_t stage [SQRT_STEPS+1];

    assign stage[0]  = chain_in;
    assign chain_out = stage[SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
        gng_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    `ASSERT_IMPLIES(a_chain_latency, aclk, aresetn, chain_out.valid, $past(chain_in.valid, SQRT_STEPS), "root left the chain without a matching entry")
    `ASSERT_IMPLIES(a_root_width, aclk, aresetn, chain_out.valid, chain_out.root[63:32] == 32'd0, "root exceeds 32 bits")

endmodule

// ===== design/gaussian_noise_generator_core.sv =====
// Top level of the Gaussian noise generator: PCG source, log, Box-Muller
// sine/cosine and output buffer. Depends on gng_pkg and gng_sqrt_chain.
//
// Usage:
//   Input stream (s_*): one transfer per request; s_tdata[0] is the restart
//   flag, which reseeds the generator from the seed and stream registers and
//   drops any saved sample before the request is served.
//   Output stream (m_*): one transfer per request; m_tdata[19:0] is a signed
//   Q3.16 normal sample, m_tuser is 1 when it is the saved sine half.
//   Config (APB): seed at byte address 0, stream at byte address 8, 64-bit
//   data; write only while no request is in flight.
//   Sequence: a request that opens a new pair runs the 28 squaring steps of the
//   log unit and the 12 Taylor term steps of the sine/cosine sequencer (the
//   32-cell root chain runs alongside). A request served from the saved sample
//   skips these steps; a restart first adds a reseed step of the generator.
//   One request at a time: the next is accepted once the sequencer is idle.
//   Reset: generator state 0, increment 1, no saved sample, seed 0, stream 1.
//   Stall: a finished sample waits in the output register; the next request
//   is accepted meanwhile and its result holds until the register frees.
`include "assert_macros.svh"

module gaussian_noise_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] sample, [23:20] zero
    output logic        m_tuser,   // [0] from_spare
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import gng_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PCG, ST_LOG_NORM, ST_LOG_SQ, ST_V_T, ST_V_HI, ST_V_LO,
        ST_SC_ANG, ST_SC_X, ST_SC_X2, ST_TERM_MUL, ST_TERM_RECIP, ST_TERM_CORR,
        ST_SC_QUAD, ST_SQRT_WAIT, ST_SCALE_COS, ST_SCALE_SIN, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {JOB_SEED, JOB_M, JOB_P} job_t;

    localparam int unsigned SCALE_SHIFT = 58 - FRAC_BITS;
    localparam logic [33:0] T_BASE      = 34'(33) << 28;
    localparam logic [64:0] MAG_LIM     = 65'(7) << FRAC_BITS;
    localparam logic [64:0] MAG_MAX     = 65'((1 << (SAMPLE_W - 1)) - 1);

    // Taylor divisors in step order: sine then cosine for each term
    localparam logic [7:0] DIV_TAB [12] = '{8'd6, 8'd2, 8'd20, 8'd12, 8'd42, 8'd30,
                                           8'd72, 8'd56, 8'd110, 8'd90, 8'd156, 8'd132};
    localparam logic [5:0] SHF_TAB [12] = '{6'd33, 6'd32, 6'd35, 6'd34, 6'd36, 6'd35,
                                           6'd37, 6'd36, 6'd37, 6'd37, 6'd38, 6'd38};
    localparam logic [31:0] RCP_TAB [12] = '{
        32'((64'd1 << 33) / 64'd6),   32'((64'd1 << 32) / 64'd2),
        32'((64'd1 << 35) / 64'd20),  32'((64'd1 << 34) / 64'd12),
        32'((64'd1 << 36) / 64'd42),  32'((64'd1 << 35) / 64'd30),
        32'((64'd1 << 37) / 64'd72),  32'((64'd1 << 36) / 64'd56),
        32'((64'd1 << 37) / 64'd110), 32'((64'd1 << 37) / 64'd90),
        32'((64'd1 << 38) / 64'd156), 32'((64'd1 << 38) / 64'd132)};

    function automatic logic [SAMPLE_W-1:0] scale_round(input logic [63:0] prod,
                                                        input logic neg);
        logic [64:0] sum;
        logic [64:0] mag;
        sum = {1'b0, prod} + (65'd1 << (SCALE_SHIFT - 1));
        mag = sum >> SCALE_SHIFT;
        if (mag > MAG_LIM) mag = MAG_LIM;
        if (mag > MAG_MAX) mag = MAG_MAX;
        return neg ? (SAMPLE_W'(0) - mag[SAMPLE_W-1:0]) : mag[SAMPLE_W-1:0];
    endfunction

    // configuration
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;

    // control
    state_t      state_reg, state_next;
    job_t        job_reg;
    logic [1:0]  pcg_phase_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  step_reg;
    logic        r_done_reg;
    logic        saved_valid_reg;
    logic        m_tvalid_reg;

    // generator
    logic [63:0] lcg_state_reg, lcg_inc_reg;
    logic [63:0] plo_reg;
    logic [31:0] phi_reg;
    logic [31:0] draw_m_reg, draw_p_reg;

    // log / radius
    logic [30:0] y_reg;
    logic [5:0]  e_reg;
    logic [27:0] frac_reg;
    logic [33:0] t_reg;
    logic [45:0] vhi_reg;
    logic [31:0] r_reg;

    // angle / Taylor
    logic [1:0]  quad_reg;
    logic        fold_reg;
    logic [61:0] xprod_reg;
    logic [29:0] x_reg, x2_reg;
    logic [30:0] ts_reg, tc_reg;
    logic signed [31:0] s_acc_reg, c_acc_reg;
    logic [29:0] n_reg;
    logic [61:0] nm_reg;
    logic [31:0] sn_mag_reg, cs_mag_reg;
    logic        sn_neg_reg, cs_neg_reg;

    // results
    logic [SAMPLE_W-1:0] saved_reg, res_reg, m_sample_reg;
    logic        res_spare_reg, m_spare_reg;

    sqrt_stage_t sq_in, sq_out;

    // combinational helpers
    logic [31:0] mul_a, mul_b, draw_val, xs;
    logic [63:0] pcg_prod;
    logic [4:0]  rot;
    logic [32:0] m_val, p_val;
    logic [5:0]  e_val;
    logic [63:0] norm_wide;
    logic [61:0] sq_full;
    logic [31:0] sq_val;
    logic [4:0]  frac_idx;
    logic [33:0] t_val;
    logic [62:0] v_sum;
    logic [30:0] ang_a, ang_b;
    logic [60:0] term_prod;
    logic [30:0] term_sel;
    logic [29:0] q_est, q_fix;
    logic [37:0] q_rem;
    logic [61:0] x2_full;
    logic signed [31:0] sa, ca, sn, cs;
    logic [63:0] scale_prod;
    logic [31:0] scale_mag;
    logic        accept, out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_sample_reg};
    assign m_tuser  = m_spare_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[3] ? {1'b0, stream_reg} : seed_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= 64'd0;
            stream_reg <= 63'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3]) begin
                stream_reg <= pwdata[62:0];
            end else begin
                seed_reg <= pwdata;
            end
        end
    end

    // PCG output permutation and shared 32x32 step multiplier
    always_comb begin
        xs       = 32'(((lcg_state_reg >> 18) ^ lcg_state_reg) >> 27);
        rot      = lcg_state_reg[63:59];
        draw_val = 32'({xs, xs} >> rot);
        case (pcg_phase_reg)
            2'd0: begin
                mul_a = lcg_state_reg[31:0];
                mul_b = PCG_MULT[31:0];
            end
            2'd1: begin
                mul_a = lcg_state_reg[31:0];
                mul_b = PCG_MULT[63:32];
            end
            default: begin
                mul_a = lcg_state_reg[63:32];
                mul_b = PCG_MULT[31:0];
            end
        endcase
        pcg_prod = 64'(mul_a) * 64'(mul_b);
    end

    // log2 front end and squaring step
    always_comb begin
        m_val = {draw_m_reg, 1'b1};
        e_val = 6'd0;
        for (int i = 0; i < 33; i++) begin
            if (m_val[i]) e_val = 6'(i);
        end
        if (e_val <= 6'd30) begin
            norm_wide = {31'b0, m_val} << (6'd30 - e_val);
        end else begin
            norm_wide = {31'b0, m_val} >> (e_val - 6'd30);
        end
        sq_full  = 62'(y_reg) * 62'(y_reg);
        sq_val   = sq_full[61:30];
        frac_idx = 5'd27 - cnt_reg;
        t_val    = T_BASE - {e_reg, frac_reg};
        v_sum    = {vhi_reg, 17'b0} + 63'(63'(t_reg[16:0]) * 63'(TWO_LN2_Q28))
                   + (63'd1 << 27);
    end

    // angle, Taylor terms and quadrant mapping
    always_comb begin
        p_val     = {draw_p_reg, 1'b1};
        ang_a     = p_val[30:0];
        ang_b     = ang_a[30] ? (31'h4000_0000 - {1'b0, ang_a[29:0]}) : ang_a;
        x2_full   = 62'(x_reg) * 62'(x_reg);
        term_sel  = step_reg[0] ? tc_reg : ts_reg;
        term_prod = 61'(term_sel) * 61'(x2_reg);
        q_est     = 30'(nm_reg >> SHF_TAB[step_reg]);
        q_rem     = 38'(n_reg) - 38'(38'(q_est) * 38'(DIV_TAB[step_reg]));
        q_fix     = (q_rem >= 38'(DIV_TAB[step_reg])) ? q_est + 30'd1 : q_est;
        sa        = fold_reg ? c_acc_reg : s_acc_reg;
        ca        = fold_reg ? s_acc_reg : c_acc_reg;
        case (quad_reg)
            2'd0: begin sn = sa;  cs = ca;  end
            2'd1: begin sn = ca;  cs = -sa; end
            2'd2: begin sn = -sa; cs = -ca; end
            default: begin sn = -ca; cs = sa; end
        endcase
        scale_mag  = (state_reg == ST_SCALE_SIN) ? sn_mag_reg : cs_mag_reg;
        scale_prod = 64'(r_reg) * 64'(scale_mag);
    end

    always_comb begin
        sq_in       = '0;
        sq_in.valid = (state_reg == ST_V_LO);
        sq_in.rem   = {2'b0, v_sum[61:28], 28'b0};
        sq_in.trial = 64'd1 << 62;
    end

    gng_sqrt_chain u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chain_in  (sq_in),
        .chain_out (sq_out)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[0] || !saved_valid_reg) state_next = ST_PCG;
                    else state_next = ST_FINISH;
                end
            end
            ST_PCG: begin
                if (pcg_phase_reg == 2'd3 && job_reg == JOB_P) state_next = ST_LOG_NORM;
            end
            ST_LOG_NORM:   state_next = ST_LOG_SQ;
            ST_LOG_SQ:     if (cnt_reg == 5'd27) state_next = ST_V_T;
            ST_V_T:        state_next = ST_V_HI;
            ST_V_HI:       state_next = ST_V_LO;
            ST_V_LO:       state_next = ST_SC_ANG;
            ST_SC_ANG:     state_next = ST_SC_X;
            ST_SC_X:       state_next = ST_SC_X2;
            ST_SC_X2:      state_next = ST_TERM_MUL;
            ST_TERM_MUL:   state_next = ST_TERM_RECIP;
            ST_TERM_RECIP: state_next = ST_TERM_CORR;
            ST_TERM_CORR:  state_next = (step_reg == 4'd11) ? ST_SC_QUAD : ST_TERM_MUL;
            ST_SC_QUAD:    state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:  if (r_done_reg) state_next = ST_SCALE_COS;
            ST_SCALE_COS:  state_next = ST_SCALE_SIN;
            ST_SCALE_SIN:  state_next = ST_FINISH;
            ST_FINISH:     if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            job_reg         <= JOB_M;
            pcg_phase_reg   <= 2'd0;
            cnt_reg         <= 5'd0;
            step_reg        <= 4'd0;
            r_done_reg      <= 1'b0;
            saved_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            lcg_state_reg   <= 64'd0;
            lcg_inc_reg     <= 64'd1;
            saved_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (sq_out.valid) r_done_reg <= 1'b1;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    pcg_phase_reg <= 2'd0;
                    if (accept) begin
                        if (s_tdata[0]) begin
                            // reseed: the first step from zero lands on the increment
                            lcg_state_reg   <= {stream_reg, 1'b1} + seed_reg;
                            lcg_inc_reg     <= {stream_reg, 1'b1};
                            saved_valid_reg <= 1'b0;
                            job_reg         <= JOB_SEED;
                        end else if (saved_valid_reg) begin
                            saved_valid_reg <= 1'b0;
                            res_reg         <= saved_reg;
                            res_spare_reg   <= 1'b1;
                        end else begin
                            job_reg <= JOB_M;
                        end
                    end
                end
                ST_PCG: begin
                    pcg_phase_reg <= pcg_phase_reg + 2'd1;
                    case (pcg_phase_reg)
                        2'd0: begin
                            plo_reg <= pcg_prod;
                            if (job_reg == JOB_M) draw_m_reg <= draw_val;
                            if (job_reg == JOB_P) draw_p_reg <= draw_val;
                        end
                        2'd1: phi_reg <= pcg_prod[31:0];
                        2'd2: phi_reg <= phi_reg + pcg_prod[31:0];
                        default: begin
                            lcg_state_reg <= {phi_reg + plo_reg[63:32], plo_reg[31:0]}
                                             + lcg_inc_reg;
                            job_reg <= (job_reg == JOB_M) ? JOB_P : JOB_M;
                        end
                    endcase
                end
                ST_LOG_NORM: begin
                    e_reg    <= e_val;
                    y_reg    <= norm_wide[30:0];
                    frac_reg <= 28'd0;
                    cnt_reg  <= 5'd0;
                end
                ST_LOG_SQ: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (sq_val[31]) begin
                        y_reg              <= sq_val[31:1];
                        frac_reg[frac_idx] <= 1'b1;
                    end else begin
                        y_reg <= sq_val[30:0];
                    end
                end
                ST_V_T:  t_reg   <= t_val;
                ST_V_HI: vhi_reg <= 46'(46'(t_reg[33:17]) * 46'(TWO_LN2_Q28));
                ST_V_LO: r_done_reg <= 1'b0;
                ST_SC_ANG: begin
                    quad_reg  <= p_val[32:31];
                    fold_reg  <= ang_a[30];
                    xprod_reg <= 62'(ang_b) * 62'(HALF_PI_Q30);
                end
                ST_SC_X: begin
                    x_reg <= 30'((xprod_reg + 62'(32'h4000_0000)) >> 31);
                end
                ST_SC_X2: begin
                    x2_reg    <= x2_full[59:30];
                    ts_reg    <= {1'b0, x_reg};
                    tc_reg    <= 31'h4000_0000;
                    s_acc_reg <= 32'(x_reg);
                    c_acc_reg <= 32'sh4000_0000;
                    step_reg  <= 4'd0;
                end
                ST_TERM_MUL:   n_reg  <= term_prod[59:30];
                ST_TERM_RECIP: nm_reg <= 62'(n_reg) * 62'(RCP_TAB[step_reg]);
                ST_TERM_CORR: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg[0]) begin
                        tc_reg <= {1'b0, q_fix};
                        if (!step_reg[1]) c_acc_reg <= c_acc_reg - 32'(q_fix);
                        else c_acc_reg <= c_acc_reg + 32'(q_fix);
                    end else begin
                        ts_reg <= {1'b0, q_fix};
                        if (!step_reg[1]) s_acc_reg <= s_acc_reg - 32'(q_fix);
                        else s_acc_reg <= s_acc_reg + 32'(q_fix);
                    end
                end
                ST_SC_QUAD: begin
                    sn_neg_reg <= sn[31];
                    cs_neg_reg <= cs[31];
                    sn_mag_reg <= sn[31] ? 32'(-sn) : 32'(sn);
                    cs_mag_reg <= cs[31] ? 32'(-cs) : 32'(cs);
                end
                ST_SCALE_COS: begin
                    res_reg       <= scale_round(scale_prod, cs_neg_reg);
                    res_spare_reg <= 1'b0;
                end
                ST_SCALE_SIN: begin
                    saved_reg       <= scale_round(scale_prod, sn_neg_reg);
                    saved_valid_reg <= 1'b1;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_sample_reg <= res_reg;
                        m_spare_reg  <= res_spare_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // hold the root as soon as it leaves the chain
    always_ff @(posedge aclk) begin
        if (sq_out.valid) r_reg <= sq_out.root[31:0];
    end

    `ASSERT_IMPLIES(a_log_norm, aclk, aresetn, state_reg == ST_LOG_SQ, y_reg[30], "log mantissa lost normalization")
    `ASSERT_IMPLIES(a_div_corr, aclk, aresetn, state_reg == ST_TERM_CORR, q_rem < {29'd0, DIV_TAB[step_reg], 1'b0}, "reciprocal quotient off by more than one")
    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted request left the sequencer idle")
    `ASSERT_IMPLIES(a_root_ready, aclk, aresetn, state_reg == ST_SCALE_COS, r_done_reg, "scaling started before the root arrived")

endmodule

// ===== tb/gaussian_noise_generator_core_tb.sv =====
// Testbench for gaussian_noise_generator_core: random and directed requests
// checked against a bit-exact PCG / Box-Muller predictor. Depends on gng_pkg.
module gaussian_noise_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gng_pkg::*;

    localparam logic [3:0] ADDR_SEED   = 4'd0;
    localparam logic [3:0] ADDR_STREAM = 4'd8;
    localparam int         IDLE_LIMIT  = 20000;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                from_spare;
    } sample_t;

    class gauss_predictor;
        longint unsigned seed_reg, stream_reg;
        longint unsigned pcg_state, pcg_inc;
        logic [SAMPLE_W-1:0] spare_sample;
        bit spare_valid;
        sample_t pending_q[$];
        int errors;

        function new();
            seed_reg = 0;
            stream_reg = 1;
            pcg_state = 0;
            pcg_inc = 1;
            spare_sample = '0;
            spare_valid = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [3:0] addr, longint unsigned value);
            if (addr == ADDR_SEED)
                seed_reg = value;
            else if (addr == ADDR_STREAM)
                stream_reg = value & 64'h7FFF_FFFF_FFFF_FFFF;
        endfunction

        function logic [31:0] pcg_draw();
            longint unsigned prev;
            logic [31:0] xs;
            logic [4:0] rot;
            prev = pcg_state;
            pcg_state = prev * PCG_MULT + pcg_inc;
            xs = 32'(((prev >> 18) ^ prev) >> 27);
            rot = 5'(prev >> 59);
            return (xs >> rot) | (xs << ((32 - rot) & 31));
        endfunction

        function longint unsigned root64(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // log2 in Q28: leading one gives the integer part, squaring the fraction
        function longint unsigned log2_fix(longint unsigned m);
            int e;
            longint unsigned y, frac;
            e = 0;
            frac = 0;
            while (e < 63 && (m >> (e + 1)) != 0) e++;
            y = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
            for (int i = 27; i >= 0; i--) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    y >>= 1;
                    frac |= 64'd1 << i;
                end
            end
            return (longint'(e) << 28) + frac;
        endfunction

        function void sin_cos(longint unsigned p, output longint sn, output longint cs);
            int unsigned q;
            longint unsigned a, b, x, x2, ts, tc;
            longint s, c, sa, ca;
            bit fold;
            q = int'((p >> 31) & 3);
            a = p & ((64'd1 << 31) - 1);
            fold = a >= (64'd1 << 30);
            b = fold ? (64'd1 << 31) - a : a;
            x = (b * HALF_PI_Q30 + (64'd1 << 30)) >> 31;
            x2 = (x * x) >> 30;
            ts = x;
            tc = 64'd1 << 30;
            s = longint'(x);
            c = longint'(64'd1 << 30);
            for (longint unsigned k = 1; k <= 6; k++) begin
                ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
                tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
                if (k[0]) begin
                    s -= longint'(ts);
                    c -= longint'(tc);
                end else begin
                    s += longint'(ts);
                    c += longint'(tc);
                end
            end
            sa = fold ? c : s;
            ca = fold ? s : c;
            case (q)
                0: begin sn = sa;  cs = ca;  end
                1: begin sn = ca;  cs = -sa; end
                2: begin sn = -sa; cs = -ca; end
                default: begin sn = -ca; cs = sa; end
            endcase
        endfunction

        // round r*t half away from zero to the output field, then saturate
        function logic [SAMPLE_W-1:0] to_sample(longint unsigned r, longint t);
            bit neg;
            longint unsigned mag, v;
            int unsigned sh;
            neg = t < 0;
            mag = neg ? longint'(-t) : longint'(t);
            sh = 58 - FRAC_BITS;
            v = (r * mag + (64'd1 << (sh - 1))) >> sh;
            if (v > (64'd7 << FRAC_BITS)) v = 64'd7 << FRAC_BITS;
            if (v > 64'd524287) v = 64'd524287;
            if (neg) v = -v;
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_request(logic [7:0] data);
            sample_t exp_s;
            longint unsigned m, p, t, v, r;
            longint sn, cs;
            logic [31:0] dummy;
            if (data[0]) begin
                pcg_state = 0;
                pcg_inc = (stream_reg << 1) | 1;
                dummy = pcg_draw();
                pcg_state += seed_reg;
                dummy = pcg_draw();
                spare_valid = 0;
            end
            if (spare_valid) begin
                spare_valid = 0;
                exp_s.sample = spare_sample;
                exp_s.from_spare = 1;
            end else begin
                m = 2 * longint'(pcg_draw()) + 1;
                p = 2 * longint'(pcg_draw()) + 1;
                t = (64'd33 << 28) - log2_fix(m);
                v = (t * TWO_LN2_Q28 + (64'd1 << 27)) >> 28;
                r = root64(v << 28);
                sin_cos(p, sn, cs);
                spare_sample = to_sample(r, sn);
                spare_valid = 1;
                exp_s.sample = to_sample(r, cs);
                exp_s.from_spare = 0;
            end
            pending_q.push_back(exp_s);
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] sample, logic from_spare);
            sample_t exp_s;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected sample %h spare %b", $time, sample, from_spare);
                errors++;
                return;
            end
            exp_s = pending_q.pop_front();
            if (sample !== exp_s.sample || from_spare !== exp_s.from_spare) begin
                $display("%0t: sample expected %h spare %b, actual %h spare %b", $time,
                         exp_s.sample, exp_s.from_spare, sample, from_spare);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [19:0] sample, [23:20] zero
    logic        m_tuser;    // [0] from_spare
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    gauss_predictor gauss = new();
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;

    gaussian_noise_generator_core dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            gauss.check_sample(m_tdata[SAMPLE_W-1:0], m_tuser);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("gaussian_noise_generator_core_tb: errors");
            $finish;
        end
    end

    // receiver: stall rate changes per stretch, with a long hold on request
    initial begin
        int stall_pct;
        int stretch;
        m_tready <= 1'b0;
        forever begin
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
            stretch = $urandom_range(50, 400);
            for (int i = 0; i < stretch; i++) begin
                @(posedge aclk);
                if (hold_req) begin
                    m_tready <= 1'b0;
                    repeat (600) @(posedge aclk);
                    hold_req = 0;
                end
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic apb_write(logic [3:0] addr, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        gauss.write_reg(addr, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(logic [7:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        gauss.note_request(data);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_random(int count, int restart_pct);
        logic [7:0] data;
        for (int i = 0; i < count; i++) begin
            data = 8'($urandom_range(0, 99) < restart_pct);
            if ($urandom_range(0, 15) == 0)
                data[7:1] = 7'($urandom);
            send_request(data);
        end
    endtask

    // wait out the in-flight requests before touching the registers
    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (gauss.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state without a reseed, then restarts mid-pair and after a pair
        send_request(8'h00);
        send_request(8'h00);
        send_request(8'h00);
        send_request(8'h01);
        send_request(8'h01);
        send_request(8'h00);
        send_request(8'h00);
        send_request(8'hFE);
        send_request(8'hFF);
        send_request(8'h00);
        send_request(8'h00);
        drain();

        apb_write(ADDR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        apb_write(ADDR_STREAM, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(8'h01);
        send_request(8'h00);
        send_request(8'h00);
        send_request(8'h01);
        drain();

        apb_write(ADDR_SEED, 64'd0);
        apb_write(ADDR_STREAM, 64'd0);
        send_request(8'h01);
        send_request(8'h00);
        send_request(8'h00);
        send_random(230, 10);
        drain();

        apb_write(ADDR_SEED, {$urandom, $urandom});
        apb_write(ADDR_STREAM, {1'b1, 31'($urandom), $urandom});
        send_request(8'h01);
        hold_req <= 1'b1;
        send_random(270, 8);
        drain();

        apb_write(ADDR_STREAM, {$urandom, $urandom});
        send_request(8'h01);
        send_random(270, 12);
        drain();

        apb_write(ADDR_SEED, {$urandom, $urandom});
        apb_write(ADDR_STREAM, 64'h8000_0000_0000_0000);
        send_request(8'h01);
        send_random(250, 15);
        drain();

        if (gauss.errors == 0)
            $display("gaussian_noise_generator_core_tb: clean");
        else
            $display("gaussian_noise_generator_core_tb: errors");
        $finish;
    end

endmodule
